/* rtl/lcdm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants, and table and saturation functions for the chirp dechirp mixer.
package lcdm_pkg;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned AMP_W      = 15;
    localparam int unsigned TAB_W      = 15;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_START_INC  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_STEP = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 2'd2;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic               frame_start;
    } lcdm_in_t;

    typedef struct packed {
        logic signed [31:0] prod_re;
        logic signed [31:0] prod_im;
        logic               frame_last;
    } lcdm_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_SIN,
        ST_SC_SIN,
        ST_SC_COS,
        ST_RE_A,
        ST_RE_B,
        ST_IM_A,
        ST_IM_B
    } lcdm_state_t;

    // Quarter-wave sine entry k, Q30 Taylor series to x^13, rounded to Q15.
    function automatic logic [TAB_W-1:0] qsine_entry(input int unsigned k,
                                                     input int unsigned qtr_shift);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(k) * HALF_PI_Q30) >> qtr_shift;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = ($unsigned(sum) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TAB_W-1:0];
    endfunction

    // Clamp a 35-bit signed sum to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > $signed(35'sh0_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed(35'sh7_8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/lcdm_sine_rom.sv */
`timescale 1ns / 1ps
// Quarter-wave sine table with registered read.
module lcdm_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              aclk,
    input  logic [SINE_TABLE_BITS-2:0]        rd_addr,
    output logic [lcdm_pkg::TAB_W-1:0]        rd_data
);

    localparam int unsigned QTR_SHIFT = SINE_TABLE_BITS - 2;
    localparam int unsigned QTR_LEN   = 1 << QTR_SHIFT;

    logic [lcdm_pkg::TAB_W-1:0] tab [QTR_LEN+1];
    logic [lcdm_pkg::TAB_W-1:0] rd_data_reg;

    for (genvar k = 0; k <= QTR_LEN; k++) begin : g_tab
        assign tab[k] = lcdm_pkg::qsine_entry(k, QTR_SHIFT);
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= tab[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/linear_chirp_dechirp_mixer.sv */
`timescale 1ns / 1ps
// Linear chirp dechirp mixer: on-the-fly chirp reference times complex sample.
// Each word passes RD_SIN, SC_SIN, SC_COS, RE_A, RE_B, IM_A, IM_B, then the output register.
// A new word is taken only once the last is through; s_ready is high only in the idle state.
//   The single 17x17 multiplier is used six times per word, and the table is read twice.
// Reset (aresetn low, synchronous): idle, no output word, phase and increment at zero,
//   sample position zero, start_increment and sweep_step zero, amplitude 32767.
module linear_chirp_dechirp_mixer #(
    parameter int FRAME_SAMPLES   = 2048,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write port
    input  logic                                 cfg_we,
    input  logic [lcdm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lcdm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lcdm_pkg::lcdm_in_t                   s_data,
    // output words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lcdm_pkg::lcdm_out_t                  m_data
);

    localparam int IDX_W  = $clog2(FRAME_SAMPLES);
    localparam int OFF_W  = SINE_TABLE_BITS - 2;
    localparam int ADDR_W = SINE_TABLE_BITS - 1;
    localparam int QTR    = 1 << OFF_W;

    // ---------------- configuration registers ----------------
    logic [31:0]                    start_inc_reg;
    logic [31:0]                    sweep_reg;
    logic [lcdm_pkg::AMP_W-1:0]     amp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_inc_reg <= '0;
            sweep_reg     <= '0;
            amp_reg       <= lcdm_pkg::AMP_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                lcdm_pkg::REG_START_INC:  start_inc_reg <= cfg_wdata;
                lcdm_pkg::REG_SWEEP_STEP: sweep_reg     <= cfg_wdata;
                lcdm_pkg::REG_AMPLITUDE:  amp_reg       <= cfg_wdata[lcdm_pkg::AMP_W-1:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ---------------- sequencer ----------------
    lcdm_pkg::lcdm_state_t state_reg, state_next;

    logic s_acc;
    logic out_free;

    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcdm_pkg::ST_IDLE:   if (s_valid) state_next = lcdm_pkg::ST_RD_SIN;
            lcdm_pkg::ST_RD_SIN: state_next = lcdm_pkg::ST_SC_SIN;
            lcdm_pkg::ST_SC_SIN: state_next = lcdm_pkg::ST_SC_COS;
            lcdm_pkg::ST_SC_COS: state_next = lcdm_pkg::ST_RE_A;
            lcdm_pkg::ST_RE_A:   state_next = lcdm_pkg::ST_RE_B;
            lcdm_pkg::ST_RE_B:   state_next = lcdm_pkg::ST_IM_A;
            lcdm_pkg::ST_IM_A:   state_next = lcdm_pkg::ST_IM_B;
            lcdm_pkg::ST_IM_B:   if (out_free) state_next = lcdm_pkg::ST_IDLE;
            default:             state_next = lcdm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcdm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- phase accumulator ----------------
    // Restart (frame_start) is applied before the word; end-of-frame restart after it.
    logic [31:0]      phase_acc_reg, phase_step_reg;
    logic [IDX_W-1:0] sample_idx_reg;
    logic [31:0]      base_acc, base_step;
    logic [IDX_W-1:0] base_idx;
    logic             base_last;

    always_comb begin
        base_acc  = s_data.frame_start ? 32'd0 : phase_acc_reg;
        base_step = s_data.frame_start ? start_inc_reg : phase_step_reg;
        base_idx  = s_data.frame_start ? '0 : sample_idx_reg;
        base_last = (base_idx == IDX_W'(FRAME_SAMPLES - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            sample_idx_reg <= '0;
        end else if (s_acc) begin
            if (base_last) begin
                phase_acc_reg  <= '0;
                phase_step_reg <= start_inc_reg;
                sample_idx_reg <= '0;
            end else begin
                phase_acc_reg  <= base_acc + base_step;
                phase_step_reg <= base_step + sweep_reg;
                sample_idx_reg <= base_idx + IDX_W'(1);
            end
        end
    end

    // ---------------- table lookup ----------------
    // sin uses the phase quadrant, cos the next one; odd quadrants mirror the offset.
    logic [1:0]                   quad_reg;
    logic [OFF_W-1:0]             off_reg;
    logic [1:0]                   rd_quad;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         rd_neg_reg;
    logic [lcdm_pkg::TAB_W-1:0]   rom_q;

    always_comb begin
        rd_quad = (state_reg == lcdm_pkg::ST_RD_SIN) ? quad_reg : quad_reg + 2'd1;
        rd_addr = rd_quad[0] ? (ADDR_W'(QTR) - {1'b0, off_reg}) : {1'b0, off_reg};
    end

    lcdm_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rom_q)
    );

    // ---------------- shared multiplier and datapath ----------------
    logic signed [15:0] a_reg, b_reg;
    logic               last_reg;
    logic signed [15:0] ci_reg, cr_reg;
    logic signed [33:0] acc_reg;
    logic signed [31:0] re_reg;
    logic signed [16:0] rom_s;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;
    logic signed [34:0] sum_sub, sum_add;

    assign rom_s = rd_neg_reg ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});

    always_comb begin
        s_ready = 1'b0;
        mul_a   = rom_s;
        mul_b   = $signed({2'b00, amp_reg});
        case (state_reg)
            lcdm_pkg::ST_IDLE: s_ready = 1'b1;
            lcdm_pkg::ST_RE_A: begin
                mul_a = {a_reg[15], a_reg};
                mul_b = {cr_reg[15], cr_reg};
            end
            lcdm_pkg::ST_RE_B: begin
                mul_a = {b_reg[15], b_reg};
                mul_b = {ci_reg[15], ci_reg};
            end
            lcdm_pkg::ST_IM_A: begin
                mul_a = {a_reg[15], a_reg};
                mul_b = {ci_reg[15], ci_reg};
            end
            lcdm_pkg::ST_IM_B: begin
                mul_a = {b_reg[15], b_reg};
                mul_b = {cr_reg[15], cr_reg};
            end
            default: ;
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign sum_sub = {acc_reg[33], acc_reg} - {prod[33], prod};
    assign sum_add = {acc_reg[33], acc_reg} + {prod[33], prod};

    always_ff @(posedge aclk) begin
        rd_neg_reg <= rd_quad[1];
        if (s_acc) begin
            a_reg    <= s_data.sample_re;
            b_reg    <= s_data.sample_im;
            last_reg <= base_last;
            quad_reg <= base_acc[31:30];
            off_reg  <= base_acc[29 -: OFF_W];
        end
        case (state_reg)
            // scaled reference = floor(table * amplitude / 2^15)
            lcdm_pkg::ST_SC_SIN: ci_reg <= prod[30:15];
            lcdm_pkg::ST_SC_COS: cr_reg <= prod[30:15];
            lcdm_pkg::ST_RE_A:   acc_reg <= prod;
            lcdm_pkg::ST_RE_B:   re_reg <= lcdm_pkg::sat32(sum_sub);
            lcdm_pkg::ST_IM_A:   acc_reg <= prod;
            default: ;
        endcase
        if (state_reg == lcdm_pkg::ST_IM_B && out_free) begin
            m_data.prod_re    <= re_reg;
            m_data.prod_im    <= lcdm_pkg::sat32(sum_add);
            m_data.frame_last <= last_reg;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (state_reg == lcdm_pkg::ST_IM_B && out_free) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

endmodule

/* rtl/lcdm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the chirp dechirp mixer, bound to the top level.
module lcdm_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input lcdm_pkg::lcdm_out_t  m_data
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // one word in flight: s_ready stays low after accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("input accepted while busy");

    // a new output word is only produced while the input side is busy
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("output word appeared without work in progress");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind linear_chirp_dechirp_mixer lcdm_checker u_lcdm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
